>>> src/bfzad_pkg.sv
// Package: shared types and constants for the black-frame zone activity detector.
package bfzad_pkg;

    localparam int unsigned NITS_W   = 18;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned GAMMA_W  = 16;
    localparam int unsigned MTHR_W   = 48;
    localparam int unsigned SUM_W    = 64;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIT_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIT_FRAC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_FRAC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RULE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_THR  = 3'd6;

    // Classified zone handed from front to back
    typedef struct packed {
        logic              counted;
        logic              lit;
        logic              dim;
        logic              add_pow;
        logic [NITS_W-1:0] nits;
        logic              last;
    } t_zone;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_MUL,
        ST_EXP,
        ST_CMP_A,
        ST_CMP_B,
        ST_DONE
    } t_state;

endpackage

>>> src/bfzad_front.sv
// Front end: takes zones, classifies them against thresholds and counts zones.
module bfzad_front
    import bfzad_pkg::*;
#(
    parameter int unsigned MAX_ZONES = 262144,
    parameter int unsigned CNT_W     = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [NITS_W-1:0] i_nits,
    input  logic              i_last,
    input  logic [NITS_W-1:0] i_lit_thr,
    input  logic [NITS_W-1:0] i_dim_thr,
    input  logic              i_rule,
    output t_zone             o_zone,
    output logic [CNT_W-1:0]  o_zone_count
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_room;

    assign w_room = (r_cnt < CNT_W'(MAX_ZONES));

    // Zone count, cleared by the last zone
    always_comb begin
        n_cnt = r_cnt;
        if (i_take) begin
            if (i_last) begin
                n_cnt = '0;
            end else if (w_room) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Classification
    always_comb begin
        o_zone.counted = w_room;
        o_zone.lit     = w_room && (i_nits > i_lit_thr);
        o_zone.dim     = w_room && (i_nits > i_dim_thr);
        o_zone.add_pow = w_room && i_rule && (i_nits != '0);
        o_zone.nits    = i_nits;
        o_zone.last    = i_last;
    end

    // Count including this zone, valid with o_zone
    assign o_zone_count = w_room ? r_cnt + 1'b1 : r_cnt;

endmodule

>>> src/bfzad_fifo.sv
// Short queue between front and back ends.
module bfzad_fifo
    import bfzad_pkg::*;
#(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [4];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_n;

    assign o_full  = (r_n == 3'd4);
    assign o_empty = (r_n == 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_n <= r_n + 3'((i_push && !o_full) ? 1 : 0) - 3'((i_pop && !o_empty) ? 1 : 0);
        end
    end

endmodule

>>> src/bfzad_back.sv
// Back end: power terms, saturating sum, frame tests over a small sequencer.
module bfzad_back
    import bfzad_pkg::*;
#(
    parameter int unsigned CNT_W = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_zone             i_zone,
    input  logic [CNT_W-1:0]  i_count,
    output logic              o_take,
    input  logic [FRAC_W-1:0] i_lit_frac,
    input  logic [FRAC_W-1:0] i_dim_frac,
    input  logic              i_rule,
    input  logic [GAMMA_W-1:0] i_gamma,
    input  logic [MTHR_W-1:0] i_mean_thr,
    output logic              o_res_valid,
    output logic              o_res,
    input  logic              i_res_take
);

    t_state r_st, n_st;

    logic [CNT_W-1:0] r_lit, r_dim, r_n;
    logic [SUM_W-1:0] r_sum;
    t_zone            r_z;
    logic signed [23:0] r_l;
    logic signed [40:0] r_y;
    logic             r_lit_ok, r_sec;
    logic             r_out_v, r_out;
    logic [SUM_W-1:0] r_lo_prod;

    // Leading-one search and Mitchell log2
    logic [4:0]  w_e;
    logic [15:0] w_f;
    logic [37:0] w_norm;
    always_comb begin
        w_e = 5'd0;
        for (int i = 0; i < NITS_W; i++) begin
            if (r_z.nits[i]) begin
                w_e = 5'(i);
            end
        end
        w_norm = ({20'd0, r_z.nits} << 20) >> w_e;
        w_f    = w_norm[19:4];
    end

    // Mitchell exp2 of r_y
    logic signed [24:0] w_k;
    logic [16:0]        w_m;
    logic [SUM_W-1:0]   w_term;
    logic [SUM_W:0]     w_add;
    always_comb begin
        w_k = 25'(r_y >>> 16) + 25'sd8;
        w_m = {1'b1, r_y[15:0]};
        if (w_k > 25'sd63) begin
            w_term = '1;
        end else if (w_k >= 25'sd16) begin
            w_term = {47'd0, w_m} << 6'(w_k - 25'sd16);
        end else if (w_k <= -25'sd48) begin
            w_term = '0;
        end else begin
            w_term = {47'd0, w_m} >> 6'(25'sd16 - w_k);
        end
        w_add = {1'b0, r_sum} + {1'b0, w_term};
    end

    // Final compare of the mean test, upper half
    logic [SUM_W-1:0] w_q;
    assign w_q = 64'(i_mean_thr[47:32]) * 64'(r_n) + (r_lo_prod >> 32);

    assign o_take      = (r_st == ST_IDLE) && i_valid && !r_out_v;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (o_take) begin
                n_st = i_zone.add_pow ? ST_LOG : (i_zone.last ? ST_CMP_A : ST_IDLE);
            end
            ST_LOG:   n_st = ST_MUL;
            ST_MUL:   n_st = ST_EXP;
            ST_EXP:   n_st = r_z.last ? ST_CMP_A : ST_IDLE;
            ST_CMP_A: n_st = ST_CMP_B;
            ST_CMP_B: n_st = ST_DONE;
            ST_DONE:  n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_lit   <= '0;
            r_dim   <= '0;
            r_sum   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_out_v && i_res_take) begin
                r_out_v <= 1'b0;
            end
            case (r_st)
                ST_IDLE: if (o_take) begin
                    r_z   <= i_zone;
                    r_n   <= i_count;
                    r_lit <= r_lit + CNT_W'(i_zone.lit);
                    r_dim <= r_dim + CNT_W'(i_zone.dim);
                end
                ST_LOG: r_l <= 24'(($signed({1'b0, w_e}) - 6'sd4) * 24'sd65536)
                               + $signed({8'd0, w_f});
                ST_MUL: r_y <= 41'(($signed(41'(r_l)) * $signed({1'b0, i_gamma})) >>> 13);
                ST_EXP: r_sum <= w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
                ST_CMP_A: begin
                    r_lit_ok  <= ({r_lit, 16'd0} > 35'(i_lit_frac) * 35'(r_n));
                    r_sec     <= ({r_dim, 16'd0} > 35'(i_dim_frac) * 35'(r_n));
                    r_lo_prod <= 64'(i_mean_thr[31:0]) * 64'(r_n);
                end
                ST_CMP_B: begin
                    if (i_rule) begin
                        r_sec <= (r_sum[63:32] > w_q) ||
                                 ((64'(r_sum[63:32]) == w_q) && (r_sum[31:0] >= r_lo_prod[31:0]));
                    end
                end
                ST_DONE: begin
                    r_out_v <= 1'b1;
                    r_out   <= r_lit_ok || r_sec;
                    r_lit   <= '0;
                    r_dim   <= '0;
                    r_sum   <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

>>> src/black_frame_zone_activity_detect.sv
// Top level of the black-frame zone activity detector.
//   channel | handshake        | payload
//   input   | i_push / o_full  | i_max_channel_nits, i_last_zone
//   result  | o_empty / i_pop  | o_frame_active
//   config  | i_cfg_we         | i_cfg_idx, i_cfg_data
// A zone is classified on entry and queued; the back end takes one zone per
// cycle while no result waits, but holds a power-term zone through log, multiply
// and exp. A last zone adds the frame tests. Reset is synchronous, active low.
// Input stalls when the four-deep queue fills; a waiting result stalls the back end.
module black_frame_zone_activity_detect
    import bfzad_pkg::*;
#(
    parameter int unsigned MAX_ZONES = 262144
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [NITS_W-1:0] i_max_channel_nits,
    input  logic              i_last_zone,
    output logic              o_empty,
    input  logic              i_pop,
    output logic              o_frame_active,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MTHR_W-1:0] i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_ZONES + 1);
    localparam int unsigned QW    = $bits(t_zone) + CNT_W;

    logic [NITS_W-1:0]  r_lit_thr, r_dim_thr;
    logic [FRAC_W-1:0]  r_lit_frac, r_dim_frac;
    logic               r_rule;
    logic [GAMMA_W-1:0] r_gamma;
    logic [MTHR_W-1:0]  r_mean_thr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit_thr  <= '0;
            r_dim_thr  <= '0;
            r_lit_frac <= 16'hFFFF;
            r_dim_frac <= 16'hFFFF;
            r_rule     <= 1'b0;
            r_gamma    <= 16'd8192;
            r_mean_thr <= 48'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LIT_THR:  r_lit_thr  <= i_cfg_data[NITS_W-1:0];
                REG_DIM_THR:  r_dim_thr  <= i_cfg_data[NITS_W-1:0];
                REG_LIT_FRAC: r_lit_frac <= i_cfg_data[FRAC_W-1:0];
                REG_DIM_FRAC: r_dim_frac <= i_cfg_data[FRAC_W-1:0];
                REG_RULE:     r_rule     <= i_cfg_data[0];
                REG_GAMMA:    r_gamma    <= i_cfg_data[GAMMA_W-1:0];
                REG_MEAN_THR: r_mean_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_zone            w_zone, w_bz;
    logic [CNT_W-1:0] w_cnt, w_bcnt;
    logic             w_take, w_qempty, w_btake, w_res_v;
    logic [QW-1:0]    w_qout;

    assign w_take = i_push && !o_full;

    bfzad_front #(.MAX_ZONES(MAX_ZONES), .CNT_W(CNT_W)) u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_nits(i_max_channel_nits),
        .i_last(i_last_zone), .i_lit_thr(r_lit_thr), .i_dim_thr(r_dim_thr),
        .i_rule(r_rule), .o_zone(w_zone), .o_zone_count(w_cnt)
    );

    bfzad_fifo #(.W(QW)) u_fifo (
        .i_clk, .i_rst_n, .i_push(i_push), .i_data({w_zone, w_cnt}), .o_full(o_full),
        .i_pop(w_btake), .o_empty(w_qempty), .o_data(w_qout)
    );

    assign w_bz   = t_zone'(w_qout[QW-1:CNT_W]);
    assign w_bcnt = w_qout[CNT_W-1:0];

    bfzad_back #(.CNT_W(CNT_W)) u_back (
        .i_clk, .i_rst_n, .i_valid(!w_qempty), .i_zone(w_bz), .i_count(w_bcnt),
        .o_take(w_btake), .i_lit_frac(r_lit_frac), .i_dim_frac(r_dim_frac),
        .i_rule(r_rule), .i_gamma(r_gamma), .i_mean_thr(r_mean_thr),
        .o_res_valid(w_res_v), .o_res(o_frame_active), .i_res_take(i_pop)
    );

    assign o_empty = !w_res_v;

`ifndef SYNTHESIS
    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty) |=> o_empty)
        else $error("result not cleared after pop");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_frame_active)))
        else $error("pending result changed");
    a_full_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_btake) |=> o_full)
        else $error("queue drained without back-end take");
`endif

endmodule
